// ===== sv/fpc_pkg.sv =====
`default_nettype none
package fpc_pkg;

  typedef struct packed {
    logic        opcode;
    logic        is_double;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
    logic [4:0]  predicate;
  } fpc_in_t;

  typedef struct packed {
    logic [63:0] mask;
    logic        zero_flag;
    logic        parity_flag;
    logic        carry_flag;
  } fpc_out_t;

  // class bits: unordered, less, equal, greater
  localparam logic [3:0] CLS_UN = 4'b0001;
  localparam logic [3:0] CLS_LT = 4'b0010;
  localparam logic [3:0] CLS_EQ = 4'b0100;
  localparam logic [3:0] CLS_GT = 4'b1000;

  localparam logic OP_MASK  = 1'b0;
  localparam logic OP_FLAGS = 1'b1;

  function automatic logic [3:0] pred_truth(input logic [3:0] p);
    logic [3:0] t;
    case (p)
      4'd0:    t = CLS_EQ;
      4'd1:    t = CLS_LT;
      4'd2:    t = CLS_LT | CLS_EQ;
      4'd3:    t = CLS_UN;
      4'd4:    t = CLS_UN | CLS_LT | CLS_GT;
      4'd5:    t = CLS_UN | CLS_EQ | CLS_GT;
      4'd6:    t = CLS_UN | CLS_GT;
      4'd7:    t = CLS_LT | CLS_EQ | CLS_GT;
      4'd8:    t = CLS_UN | CLS_EQ;
      4'd9:    t = CLS_UN | CLS_LT;
      4'd10:   t = CLS_UN | CLS_LT | CLS_EQ;
      4'd11:   t = 4'b0000;
      4'd12:   t = CLS_LT | CLS_GT;
      4'd13:   t = CLS_EQ | CLS_GT;
      4'd14:   t = CLS_GT;
      default: t = 4'b1111;
    endcase
    return t;
  endfunction

  // per-stage control carried along the pipe
  typedef struct packed {
    logic       opcode;
    logic       is_double;
    logic [3:0] pred;
  } fpc_ctl_t;

  // stage 1 -> 2: operand decode and split magnitude compares
  typedef struct packed {
    fpc_ctl_t    ctl;
    logic        nan;
    logic        both_zero;
    logic        neg_a;
    logic        neg_b;
    logic        hi_eq;
    logic        hi_lt;
    logic        lo_eq;
    logic        lo_lt;
  } fpc_dec_t;

endpackage
`default_nettype wire

// ===== sv/fpc_decode.sv =====
`default_nettype none
module fpc_decode import fpc_pkg::*; (
  input  wire fpc_in_t  din,
  output fpc_dec_t      dout
);
  logic [63:0] a, b;
  logic        nan_a, nan_b, zero_a, zero_b;
  logic [31:0] ma_hi, mb_hi, ma_lo, mb_lo;

  always_comb begin
    a = din.is_double ? din.operand_a : {32'd0, din.operand_a[31:0]};
    b = din.is_double ? din.operand_b : {32'd0, din.operand_b[31:0]};
    if (din.is_double) begin
      nan_a  = (a[62:52] == 11'h7ff) && (a[51:0] != '0);
      nan_b  = (b[62:52] == 11'h7ff) && (b[51:0] != '0);
      zero_a = a[62:0] == '0;
      zero_b = b[62:0] == '0;
      ma_hi  = {1'b0, a[62:32]};
      mb_hi  = {1'b0, b[62:32]};
      dout.neg_a = a[63];
      dout.neg_b = b[63];
    end else begin
      nan_a  = (a[30:23] == 8'hff) && (a[22:0] != '0);
      nan_b  = (b[30:23] == 8'hff) && (b[22:0] != '0);
      zero_a = a[30:0] == '0;
      zero_b = b[30:0] == '0;
      ma_hi  = '0;
      mb_hi  = '0;
      dout.neg_a = a[31];
      dout.neg_b = b[31];
    end
    // low half: single uses only 31 magnitude bits
    ma_lo = din.is_double ? a[31:0] : {1'b0, a[30:0]};
    mb_lo = din.is_double ? b[31:0] : {1'b0, b[30:0]};
    dout.ctl.opcode    = din.opcode;
    dout.ctl.is_double = din.is_double;
    dout.ctl.pred      = din.predicate[3:0];
    dout.nan       = nan_a | nan_b;
    dout.both_zero = zero_a & zero_b;
    dout.hi_eq     = ma_hi == mb_hi;
    dout.hi_lt     = ma_hi < mb_hi;
    dout.lo_eq     = ma_lo == mb_lo;
    dout.lo_lt     = ma_lo < mb_lo;
  end
endmodule
`default_nettype wire

// ===== sv/fpc_classify.sv =====
`default_nettype none
module fpc_classify import fpc_pkg::*; (
  input  wire fpc_dec_t din,
  output logic [3:0]    cls
);
  logic mag_eq, mag_lt;

  always_comb begin
    mag_eq = din.hi_eq & din.lo_eq;
    mag_lt = din.hi_lt | (din.hi_eq & din.lo_lt);
    if (din.nan)                    cls = CLS_UN;
    else if (din.both_zero)         cls = CLS_EQ;
    else if (din.neg_a != din.neg_b) cls = din.neg_a ? CLS_LT : CLS_GT;
    else if (mag_eq)                cls = CLS_EQ;
    else if (mag_lt)                cls = din.neg_a ? CLS_GT : CLS_LT;
    else                            cls = din.neg_a ? CLS_LT : CLS_GT;
  end
endmodule
`default_nettype wire

// ===== sv/fpc_result.sv =====
`default_nettype none
module fpc_result import fpc_pkg::*; (
  input  wire fpc_ctl_t ctl,
  input  wire [3:0]     cls,
  output fpc_out_t      dout
);
  always_comb begin
    dout = '0;
    if (ctl.opcode == OP_FLAGS) begin
      dout.zero_flag   = |(cls & (CLS_UN | CLS_EQ));
      dout.parity_flag = |(cls & CLS_UN);
      dout.carry_flag  = |(cls & (CLS_UN | CLS_LT));
    end else if (|(pred_truth(ctl.pred) & cls)) begin
      dout.mask = ctl.is_double ? {64{1'b1}} : {32'd0, {32{1'b1}}};
    end
  end
endmodule
`default_nettype wire

// ===== sv/fp_compare_predicate_and_flags_unit.sv =====
`default_nettype none
// Throughput: one word per cycle unless the output stalls; stage 1 decodes
// operands and splits the magnitude compare into 32-bit halves, stage 2
// classifies, stage 3 builds mask/flags. The whole pipe advances together
// when the output is empty or not stalled.
// Reset clears the valid bits; payload registers are not reset.
module fp_compare_predicate_and_flags_unit import fpc_pkg::*; (
  input  wire       clk,
  input  wire       rst,
  input  wire       in_valid,
  output logic      in_stall,
  input  wire fpc_in_t in_data,
  output logic      out_valid,
  input  wire       out_stall,
  output fpc_out_t  out_data
);
  logic     v1, v2;
  fpc_dec_t s1, dec;
  fpc_ctl_t c2;
  logic [3:0] cls2, cls;
  fpc_out_t res;
  logic     adv;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  fpc_decode   u_dec (.din(in_data), .dout(dec));
  fpc_classify u_cls (.din(s1), .cls(cls));
  fpc_result   u_res (.ctl(c2), .cls(cls2), .dout(res));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
    if (adv) begin
      s1 <= dec;
      c2 <= s1.ctl;
      cls2 <= cls;
      out_data <= res;
    end
  end

  a_cls_onehot: assert property (@(posedge clk) disable iff (rst)
    v2 |-> $onehot(cls2)) else $error("class not one-hot");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output word changed under stall");
  a_flag_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.mask != '0) |-> !out_data.zero_flag && !out_data.carry_flag)
    else $error("mask and flags both set");
  a_pipe: assert property (@(posedge clk) disable iff (rst)
    !in_stall && !out_stall |=> out_valid == $past(v2))
    else $error("pipe valid lost");
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
module tb;
  import fpc_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 8;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  fpc_in_t in_data;
  logic out_valid;
  logic out_stall;
  fpc_out_t out_data;

  fpc_out_t expected_q[$];
  int n_errors = 0;
  int idle_pct;
  int stall_pct;
  int quiet_cycles = 0;

  fp_compare_predicate_and_flags_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // class of the operand pair: unordered, less, equal or greater
  function automatic logic [3:0] order_class(input logic [63:0] a, input logic [63:0] b,
                                             input logic dbl);
    logic nan_a, nan_b, neg_a, neg_b;
    logic [63:0] mag_a, mag_b;
    if (dbl) begin
      nan_a = (a[62:52] == 11'h7ff) && (a[51:0] != 0);
      nan_b = (b[62:52] == 11'h7ff) && (b[51:0] != 0);
      neg_a = a[63];
      neg_b = b[63];
      mag_a = {1'b0, a[62:0]};
      mag_b = {1'b0, b[62:0]};
    end else begin
      nan_a = (a[30:23] == 8'hff) && (a[22:0] != 0);
      nan_b = (b[30:23] == 8'hff) && (b[22:0] != 0);
      neg_a = a[31];
      neg_b = b[31];
      mag_a = {33'd0, a[30:0]};
      mag_b = {33'd0, b[30:0]};
    end
    if (nan_a || nan_b) return CLS_UN;
    if (mag_a == 0 && mag_b == 0) return CLS_EQ;
    if (neg_a != neg_b) return neg_a ? CLS_LT : CLS_GT;
    if (mag_a == mag_b) return CLS_EQ;
    if (mag_a < mag_b) return neg_a ? CLS_GT : CLS_LT;
    return neg_a ? CLS_LT : CLS_GT;
  endfunction

  function automatic logic [3:0] predicate_set(input logic [3:0] p);
    logic [3:0] s;
    case (p)
      4'd0:  s = CLS_EQ;
      4'd1:  s = CLS_LT;
      4'd2:  s = CLS_LT | CLS_EQ;
      4'd3:  s = CLS_UN;
      4'd4:  s = CLS_UN | CLS_LT | CLS_GT;
      4'd5:  s = CLS_UN | CLS_EQ | CLS_GT;
      4'd6:  s = CLS_UN | CLS_GT;
      4'd7:  s = CLS_LT | CLS_EQ | CLS_GT;
      4'd8:  s = CLS_UN | CLS_EQ;
      4'd9:  s = CLS_UN | CLS_LT;
      4'd10: s = CLS_UN | CLS_LT | CLS_EQ;
      4'd11: s = 4'b0000;
      4'd12: s = CLS_LT | CLS_GT;
      4'd13: s = CLS_EQ | CLS_GT;
      4'd14: s = CLS_GT;
      default: s = 4'b1111;
    endcase
    return s;
  endfunction

  function automatic fpc_out_t compare_result(input fpc_in_t w);
    fpc_out_t r;
    logic [3:0] cls;
    cls = order_class(w.operand_a, w.operand_b, w.is_double);
    r = '0;
    if (w.opcode == OP_FLAGS) begin
      r.zero_flag = |(cls & (CLS_UN | CLS_EQ));
      r.parity_flag = |(cls & CLS_UN);
      r.carry_flag = |(cls & (CLS_UN | CLS_LT));
    end else if (|(predicate_set(w.predicate[3:0]) & cls)) begin
      r.mask = w.is_double ? 64'hffff_ffff_ffff_ffff : 64'h0000_0000_ffff_ffff;
    end
    return r;
  endfunction

  function automatic fpc_in_t junk_word();
    logic [159:0] r;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return r[$bits(fpc_in_t)-1:0];
  endfunction

  task automatic send_word(input fpc_in_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      in_data <= junk_word();
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    expected_q.push_back(compare_result(w));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // receiver stall and result check
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected word: mask %h", out_data.mask);
          n_errors++;
        end else begin
          fpc_out_t e;
          e = expected_q.pop_front();
          if (out_data.mask !== e.mask) begin
            $error("mask exp %h got %h", e.mask, out_data.mask);
            n_errors++;
          end
          if (out_data.zero_flag !== e.zero_flag) begin
            $error("zero_flag exp %b got %b", e.zero_flag, out_data.zero_flag);
            n_errors++;
          end
          if (out_data.parity_flag !== e.parity_flag) begin
            $error("parity_flag exp %b got %b", e.parity_flag, out_data.parity_flag);
            n_errors++;
          end
          if (out_data.carry_flag !== e.carry_flag) begin
            $error("carry_flag exp %b got %b", e.carry_flag, out_data.carry_flag);
            n_errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic fpc_in_t make_word(input logic op, input logic dbl,
                                        input logic [63:0] a, input logic [63:0] b,
                                        input logic [4:0] p);
    fpc_in_t w;
    w.opcode = op;
    w.is_double = dbl;
    w.operand_a = a;
    w.operand_b = b;
    w.predicate = p;
    return w;
  endfunction

  // operand with a bias toward zeros, infinities, NaNs and near-equal values
  function automatic logic [63:0] pick_operand(input logic dbl, input logic [63:0] other);
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(9))
      0: v = dbl ? {v[63], 63'd0} : {v[63:32], v[31], 31'd0};
      1: v = dbl ? {v[63], 11'h7ff, 52'd0} : {v[63:32], v[31], 8'hff, 23'd0};
      2: v = dbl ? {v[63], 11'h7ff, v[51:0] | 52'd1}
                 : {v[63:32], v[31], 8'hff, v[22:0] | 23'd1};
      3: v = other;
      4: v = {v[63:32], other[31:0]} ^ (dbl ? 64'h8000_0000_0000_0000 : 64'h8000_0000);
      5: v = other + 64'($urandom_range(2)) - 64'd1;
      6: v = dbl ? {v[63:52], 52'd0} | 64'($urandom_range(3)) : v;
      default: ;
    endcase
    return v;
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    in_data <= junk_word();
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [63:0] dv[8];
    logic [63:0] sv[8];
    dv = '{64'h0, 64'h8000_0000_0000_0000, 64'h7ff0_0000_0000_0000, 64'hfff0_0000_0000_0000,
           64'h7ff8_0000_0000_0000, 64'h7ff0_0000_0000_0001, 64'h3ff0_0000_0000_0000,
           64'hffff_ffff_ffff_ffff};
    sv = '{64'hffff_ffff_0000_0000, 64'h8000_0000, 64'h7f80_0000, 64'hff80_0000,
           64'hffc0_0000, 64'h7f80_0001, 64'h3f80_0000, 64'h0000_0000_bf80_0000};
    idle_pct = 0;
    stall_pct = 0;
    send_word(make_word(OP_FLAGS, 1'b1, dv[0], dv[1], 5'd0));
    send_word(make_word(OP_FLAGS, 1'b0, sv[0], sv[1], 5'd31));
    send_word(make_word(OP_FLAGS, 1'b1, dv[4], dv[6], 5'd0));
    send_word(make_word(OP_FLAGS, 1'b0, sv[7], sv[6], 5'd0));
    send_word(make_word(OP_FLAGS, 1'b1, dv[2], dv[3], 5'd0));
    for (int p = 0; p < 32; p += 2) begin
      send_word(make_word(OP_MASK, p[1], dv[p % 8], dv[(p + 5) % 8], 5'(p)));
      send_word(make_word(OP_MASK, 1'b0, sv[p % 8], sv[(p + 3) % 8], 5'(p + 1)));
    end
    drain();
  endtask

  task automatic test_random(input int n, input int idle, input int stall);
    logic dbl;
    logic [63:0] a;
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      dbl = 1'($urandom_range(1));
      a = pick_operand(dbl, {$urandom, $urandom});
      send_word(make_word(1'($urandom_range(1)), dbl, a, pick_operand(dbl, a),
                          5'($urandom)));
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    idle_pct = 0;
    stall_pct = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(130, 0, 0);
    test_random(120, 75, 0);
    drain();
    test_random(120, 0, 75);
    test_random(130, 11, 11);
    drain();
    stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
